// ----- rtl/tfc_pkg.sv -----
`default_nettype none

package tfc_pkg;

  typedef enum logic [1:0] {
    MODE_HEIGHT = 2'd0,
    MODE_OCEAN  = 2'd1,
    MODE_TEMP   = 2'd2,
    MODE_RAIN   = 2'd3
  } mode_t;

  // configuration register indexes
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_SEA  = 1'b1;

  typedef enum logic [2:0] {
    BAND_BEACH    = 3'd0,
    BAND_LOWLAND  = 3'd1,
    BAND_HIGHLAND = 3'd2,
    BAND_MOUNTAIN = 3'd3,
    BAND_SNOW     = 3'd4,
    BAND_OCEAN    = 3'd5
  } band_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // side data that rides along the divider pipeline
  typedef struct packed {
    band_t band;
    mode_t mode;
    rgb_t  color;
  } side_t;

  localparam rgb_t OCEAN_FLAG_SEA  = '{r: 8'd30,  g: 8'd90,  b: 8'd180};
  localparam rgb_t OCEAN_FLAG_LAND = '{r: 8'd120, g: 8'd170, b: 8'd80};
  localparam logic [7:0] TEMP_GREEN = 8'd30;

  function automatic rgb_t band_lo(band_t band);
    rgb_t c;
    case (band)
      BAND_BEACH:    c = '{r: 8'd205, g: 8'd185, b: 8'd120};
      BAND_LOWLAND:  c = '{r: 8'd100, g: 8'd178, b: 8'd62};
      BAND_HIGHLAND: c = '{r: 8'd148, g: 8'd132, b: 8'd84};
      BAND_MOUNTAIN: c = '{r: 8'd132, g: 8'd122, b: 8'd116};
      BAND_SNOW:     c = '{r: 8'd242, g: 8'd242, b: 8'd246};
      BAND_OCEAN:    c = '{r: 8'd40,  g: 8'd95,  b: 8'd195};
      default:       c = '{r: 8'd242, g: 8'd242, b: 8'd246};
    endcase
    return c;
  endfunction

  function automatic rgb_t band_hi(band_t band);
    rgb_t c;
    case (band)
      BAND_BEACH:    c = '{r: 8'd165, g: 8'd148, b: 8'd95};
      BAND_LOWLAND:  c = '{r: 8'd55,  g: 8'd120, b: 8'd30};
      BAND_HIGHLAND: c = '{r: 8'd95,  g: 8'd85,  b: 8'd50};
      BAND_MOUNTAIN: c = '{r: 8'd85,  g: 8'd78,  b: 8'd74};
      BAND_SNOW:     c = '{r: 8'd185, g: 8'd183, b: 8'd190};
      BAND_OCEAN:    c = '{r: 8'd10,  g: 8'd30,  b: 8'd90};
      default:       c = '{r: 8'd242, g: 8'd242, b: 8'd246};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tfc_div.sv -----
`default_nettype none

// pipelined restoring divider: q = floor(num * 2^W / den), requires num <= den
module tfc_div #(
  parameter int W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [W-1:0]     in_num,
  input  wire logic [W:0]       in_den,
  input  wire tfc_pkg::side_t   in_side,
  output logic                  out_valid,
  output logic [W:0]            out_q,
  output tfc_pkg::side_t        out_side
);

  localparam int NST = W + 1;

  logic             vld  [1:NST];
  logic [W:0]       rem  [1:NST];
  logic [W:0]       den  [1:NST];
  logic [W:0]       quo  [1:NST];
  tfc_pkg::side_t   side [1:NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic             v_in;
    logic [W:0]       r_in;
    logic [W:0]       d_in;
    logic [W:0]       q_in;
    tfc_pkg::side_t   s_in;
    logic [W+1:0]     shifted;
    logic [W+1:0]     diff;
    logic             ge;

    // the first stage works straight off the inputs
    if (k == 0) begin : g_head
      assign v_in = in_valid;
      assign r_in = {1'b0, in_num};
      assign d_in = in_den;
      assign q_in = '0;
      assign s_in = in_side;
    end else begin : g_body
      assign v_in = vld[k];
      assign r_in = rem[k];
      assign d_in = den[k];
      assign q_in = quo[k];
      assign s_in = side[k];
    end

    // first stage compares num itself (quotient msb), later ones shift in a zero
    assign shifted = (k == 0) ? {1'b0, r_in} : {r_in, 1'b0};
    assign diff    = shifted - {1'b0, d_in};
    assign ge      = (shifted >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= v_in;
      end
      rem[k+1]  <= ge ? diff[W:0] : shifted[W:0];
      den[k+1]  <= d_in;
      quo[k+1]  <= q_in | ((W+1)'(ge) << (W - k));
      side[k+1] <= s_in;
    end
  end

  assign out_valid = vld[NST];
  assign out_q     = quo[NST];
  assign out_side  = side[NST];

endmodule

`default_nettype wire

// ----- rtl/terrain_false_color_mapper.sv -----
`default_nettype none

// channel      direction  handshake          payload
// command in   in         start / busy       sample, is_ocean
// result out   out        done (one cycle)   red, green, blue
// config       in         cfg_we             cfg_index, cfg_data
//
// one sample enters per clock outside reset; each result transfer follows its
// start transfer through the input register, the divider stages (one per
// quotient bit), the mixing multipliers and the output register
// rst is synchronous and clears all valid bits and the configuration registers to
// their defaults; busy is high only while rst is high
// the pipeline never stalls and done cannot be held off by the receiver
module terrain_false_color_mapper #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] sample,
  input  wire logic        is_ocean,
  output logic             done,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int SB = SAMPLE_BITS;
  // product width of a signed color delta times a weight in [0, ONE]
  localparam int PW = SB + 11;
  localparam logic [SB:0] ONE = {1'b1, {SB{1'b0}}};

  // land band ends, rounded to the sample grid
  localparam logic [SB:0] BAND_END [5] = '{
    (SB+1)'((40 * (2 ** SB) + 50) / 100),
    (SB+1)'((58 * (2 ** SB) + 50) / 100),
    (SB+1)'((72 * (2 ** SB) + 50) / 100),
    (SB+1)'((87 * (2 ** SB) + 50) / 100),
    ONE
  };
  // lower end of each band; beach starts at sea level, filled in below
  localparam logic [SB:0] BAND_PREV [5] = '{
    '0,
    (SB+1)'((40 * (2 ** SB) + 50) / 100),
    (SB+1)'((58 * (2 ** SB) + 50) / 100),
    (SB+1)'((72 * (2 ** SB) + 50) / 100),
    (SB+1)'((87 * (2 ** SB) + 50) / 100)
  };
  localparam logic [SB-1:0] SEA_RESET = SB'((35 * (2 ** SB) + 50) / 100);

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  tfc_pkg::mode_t  overlay_mode;
  logic [SB-1:0]   shore_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      overlay_mode <= tfc_pkg::MODE_HEIGHT;
      shore_level  <= SEA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tfc_pkg::REG_MODE: overlay_mode <= tfc_pkg::mode_t'(cfg_data[1:0]);
        tfc_pkg::REG_SEA:  shore_level  <= SB'(cfg_data);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: input register
  // ---------------------------------------------------------------------
  logic          accept;
  logic          v1;
  logic [SB-1:0] s1;
  logic          oc1;

  assign busy   = rst;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    s1  <= SB'(sample);
    oc1 <= is_ocean;
  end

  // band search and divider operands, plus the colors of the other modes
  logic [SB:0]     s_ext;
  logic [SB:0]     sl_ext;
  logic [SB:0]     s_inv;
  logic [SB:0]     end_c;
  logic [SB:0]     prev_c;
  logic [SB:0]     width_c;
  logic [SB-1:0]   num_c;
  logic [SB:0]     den_c;
  tfc_pkg::band_t  band_c;
  tfc_pkg::rgb_t   col_c;
  tfc_pkg::side_t  side_c;
  logic [SB+9:0]   temp_r_p;
  logic [SB+9:0]   temp_b_p;
  logic [SB+9:0]   rain_r_p;
  logic [SB+9:0]   rain_g_p;
  logic [SB+9:0]   rain_b_p;
  logic [7:0]      temp_r;
  logic [7:0]      temp_b;

  always_comb begin
    s_ext  = {1'b0, s1};
    sl_ext = {1'b0, shore_level};
    s_inv  = ONE - s_ext;

    // first band whose end is at or above the sample; the lowest index wins
    band_c = tfc_pkg::BAND_SNOW;
    end_c  = BAND_END[4];
    prev_c = BAND_PREV[4];
    for (int i = 4; i >= 0; i--) begin
      if (s_ext <= BAND_END[i]) begin
        band_c = tfc_pkg::band_t'(3'(i));
        end_c  = BAND_END[i];
        prev_c = BAND_PREV[i];
      end
    end
    if (band_c == tfc_pkg::BAND_BEACH) begin
      prev_c = sl_ext;
    end
    width_c = end_c - prev_c;

    if (s_ext < sl_ext) begin
      // ocean gradient, weight is sample over sea level
      band_c = tfc_pkg::BAND_OCEAN;
      num_c  = s1;
      den_c  = sl_ext;
    end else if (end_c > prev_c) begin
      num_c = SB'(s_ext - prev_c);
      den_c = width_c;
    end else begin
      // empty band: zero over one gives a zero weight
      num_c = '0;
      den_c = (SB+1)'(1);
    end

    // temperature halves saturate at the midpoint
    temp_r_p = (SB+10)'(s_ext) * (SB+10)'(510);
    temp_b_p = (SB+10)'(s_inv) * (SB+10)'(510);
    temp_r   = s1[SB-1] ? 8'hFF : temp_r_p[SB+7:SB];
    temp_b   = (s_inv[SB] | s_inv[SB-1]) ? 8'hFF : temp_b_p[SB+7:SB];

    rain_r_p = (SB+10)'(s_inv) * (SB+10)'(20);
    rain_g_p = (SB+10)'(s_ext) * (SB+10)'(120);
    rain_b_p = (SB+10)'(s_ext) * (SB+10)'(155);

    case (overlay_mode)
      tfc_pkg::MODE_OCEAN: col_c = oc1 ? tfc_pkg::OCEAN_FLAG_SEA : tfc_pkg::OCEAN_FLAG_LAND;
      tfc_pkg::MODE_TEMP:  col_c = '{r: temp_r, g: tfc_pkg::TEMP_GREEN, b: temp_b};
      tfc_pkg::MODE_RAIN:  col_c = '{r: rain_r_p[SB+7:SB],
                                     g: 8'd80 + rain_g_p[SB+7:SB],
                                     b: 8'd100 + rain_b_p[SB+7:SB]};
      default:             col_c = '0;
    endcase

    side_c = '{band: band_c, mode: overlay_mode, color: col_c};
  end

  // ---------------------------------------------------------------------
  // divider: one quotient bit per stage gives the weight t
  // ---------------------------------------------------------------------
  logic            dv;
  logic [SB:0]     dq;
  tfc_pkg::side_t  dside;

  tfc_div #(
    .W (SB)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_num    (num_c),
    .in_den    (den_c),
    .in_side   (side_c),
    .out_valid (dv),
    .out_q     (dq),
    .out_side  (dside)
  );

  // ---------------------------------------------------------------------
  // mixing multipliers: (hi - lo) * t per channel
  // ---------------------------------------------------------------------
  tfc_pkg::rgb_t         lo_c;
  tfc_pkg::rgb_t         hi_c;
  logic signed [8:0]     d_r, d_g, d_b;
  logic signed [PW-1:0]  t_ext;

  always_comb begin
    lo_c  = tfc_pkg::band_lo(dside.band);
    hi_c  = tfc_pkg::band_hi(dside.band);
    d_r   = $signed({1'b0, hi_c.r}) - $signed({1'b0, lo_c.r});
    d_g   = $signed({1'b0, hi_c.g}) - $signed({1'b0, lo_c.g});
    d_b   = $signed({1'b0, hi_c.b}) - $signed({1'b0, lo_c.b});
    t_ext = $signed(PW'(dq));
  end

  logic                  mv;
  logic signed [PW-1:0]  prod_r, prod_g, prod_b;
  tfc_pkg::rgb_t         m_lo;
  tfc_pkg::side_t        m_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else begin
      mv <= dv;
    end
    prod_r <= PW'(d_r) * t_ext;
    prod_g <= PW'(d_g) * t_ext;
    prod_b <= PW'(d_b) * t_ext;
    m_lo   <= lo_c;
    m_side <= dside;
  end

  // ---------------------------------------------------------------------
  // output register: lo + floor(delta * t / ONE), or the flat mode color
  // ---------------------------------------------------------------------
  logic signed [PW-1:0]  sh_r, sh_g, sh_b;
  tfc_pkg::rgb_t         mix_c;
  tfc_pkg::rgb_t         res_c;

  always_comb begin
    sh_r    = prod_r >>> SB;
    sh_g    = prod_g >>> SB;
    sh_b    = prod_b >>> SB;
    mix_c.r = m_lo.r + sh_r[7:0];
    mix_c.g = m_lo.g + sh_g[7:0];
    mix_c.b = m_lo.b + sh_b[7:0];
    res_c   = (m_side.mode == tfc_pkg::MODE_HEIGHT) ? mix_c : m_side.color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mv;
    end
    red   <= res_c.r;
    green <= res_c.g;
    blue  <= res_c.b;
  end

endmodule

`default_nettype wire

// ----- rtl/tfc_checker.sv -----
`default_nettype none

module tfc_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  localparam int LAT = SAMPLE_BITS + 4;

  // nothing is taken while reset holds
  a_busy_in_reset: assert property (@(posedge clk) rst |-> busy)
    else $error("busy low during reset");

  // reset flushes every item in flight
  a_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result after reset");

  // every transfer in gives exactly one result a fixed time later
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result missing");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a transfer in");

endmodule

bind terrain_false_color_mapper tfc_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_tfc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

`default_nettype wire

// ----- verif/colormap_checker.sv -----
`timescale 1ns / 1ps

module colormap_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [15:0] sample,
  input  wire logic        is_ocean,
  input  wire logic        done,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               errors,
  output int               outstanding
);

  localparam int     FRAC_BITS  = 16;
  localparam longint FX_ONE     = longint'(1) << FRAC_BITS;
  localparam int     LAND_BANDS = 5;

  // band tops in percent of full scale
  localparam int unsigned BAND_PCT [LAND_BANDS] = '{40, 58, 72, 87, 100};

  // beach, lowland, highland, mountain, snow
  localparam tfc_pkg::rgb_t LAND_LO [LAND_BANDS] = '{
    {8'd205, 8'd185, 8'd120},
    {8'd100, 8'd178, 8'd62},
    {8'd148, 8'd132, 8'd84},
    {8'd132, 8'd122, 8'd116},
    {8'd242, 8'd242, 8'd246}
  };
  localparam tfc_pkg::rgb_t LAND_HI [LAND_BANDS] = '{
    {8'd165, 8'd148, 8'd95},
    {8'd55,  8'd120, 8'd30},
    {8'd95,  8'd85,  8'd50},
    {8'd85,  8'd78,  8'd74},
    {8'd185, 8'd183, 8'd190}
  };

  localparam tfc_pkg::rgb_t DEEP_LO   = {8'd40,  8'd95,  8'd195};
  localparam tfc_pkg::rgb_t DEEP_HI   = {8'd10,  8'd30,  8'd90};
  localparam tfc_pkg::rgb_t FLAG_SEA  = {8'd30,  8'd90,  8'd180};
  localparam tfc_pkg::rgb_t FLAG_LAND = {8'd120, 8'd170, 8'd80};

  tfc_pkg::mode_t mode_reg;
  logic [15:0]    sea_reg;
  tfc_pkg::rgb_t  color_fifo [$];

  function automatic logic [7:0] blend(logic [7:0] a, logic [7:0] b, longint t);
    longint v;
    v = longint'(a) * FX_ONE + (longint'(b) - longint'(a)) * t;
    if (v < 0) v = 0;
    return 8'(v >> FRAC_BITS);
  endfunction

  function automatic tfc_pkg::rgb_t ramp(tfc_pkg::rgb_t lo, tfc_pkg::rgb_t hi, longint t);
    tfc_pkg::rgb_t c;
    if (t > FX_ONE) t = FX_ONE;
    c.r = blend(lo.r, hi.r, t);
    c.g = blend(lo.g, hi.g, t);
    c.b = blend(lo.b, hi.b, t);
    return c;
  endfunction

  // truncating Q1.16 quotient, capped at one
  function automatic longint ratio(longint num, longint den);
    longint q;
    if (den == 0) return 0;
    q = (num << FRAC_BITS) / den;
    return (q > FX_ONE) ? FX_ONE : q;
  endfunction

  function automatic tfc_pkg::rgb_t relief_color(longint h);
    longint        sl;
    longint        prev;
    longint        band_top;
    longint        t;
    tfc_pkg::rgb_t c;
    bit            found;
    sl = longint'(sea_reg);
    if (h < sl) return ramp(DEEP_LO, DEEP_HI, ratio(h, sl));
    prev  = sl;
    found = 1'b0;
    c     = LAND_LO[LAND_BANDS-1];
    for (int i = 0; i < LAND_BANDS; i++) begin
      if (!found) begin
        band_top = (longint'(BAND_PCT[i]) * FX_ONE + 50) / 100;
        if (h <= band_top) begin
          t     = (band_top > prev) ? ratio(h - prev, band_top - prev) : 0;
          c     = ramp(LAND_LO[i], LAND_HI[i], t);
          found = 1'b1;
        end
        prev = band_top;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] warm_level(longint s);
    if (2 * s >= FX_ONE) return 8'd255;
    return 8'((2 * s * 255) >> FRAC_BITS);
  endfunction

  function automatic tfc_pkg::rgb_t map_color(logic [15:0] s_in, logic ocean);
    longint        s;
    tfc_pkg::rgb_t c;
    s = longint'(s_in);
    case (mode_reg)
      tfc_pkg::MODE_OCEAN: c = ocean ? FLAG_SEA : FLAG_LAND;
      tfc_pkg::MODE_TEMP: begin
        c.r = warm_level(s);
        c.g = 8'd30;
        c.b = warm_level(FX_ONE - s);
      end
      tfc_pkg::MODE_RAIN: begin
        c.r = 8'((20 * (FX_ONE - s)) >> FRAC_BITS);
        c.g = 8'(80 + ((120 * s) >> FRAC_BITS));
        c.b = 8'(100 + ((155 * s) >> FRAC_BITS));
      end
      default: c = relief_color(s);
    endcase
    return c;
  endfunction

  always @(posedge clk) begin : watch
    tfc_pkg::rgb_t want;
    int            bad;
    bad = 0;
    if (rst) begin
      mode_reg <= tfc_pkg::MODE_HEIGHT;
      sea_reg  <= 16'd22938;  // 0.35 of full scale
      color_fifo.delete();
      outstanding <= 0;
      errors      <= 0;
    end else begin
      // retire before push so a zero-depth queue never matches itself
      if (done) begin
        if (color_fifo.size() == 0) begin
          $error("unexpected result transfer: red %0d green %0d blue %0d", red, green, blue);
          bad++;
        end else begin
          want = color_fifo.pop_front();
          if (red !== want.r) begin
            $error("red: expected %0d, actual %0d", want.r, red);
            bad++;
          end
          if (green !== want.g) begin
            $error("green: expected %0d, actual %0d", want.g, green);
            bad++;
          end
          if (blue !== want.b) begin
            $error("blue: expected %0d, actual %0d", want.b, blue);
            bad++;
          end
        end
      end
      if (start && !busy) color_fifo.push_back(map_color(sample, is_ocean));
      if (cfg_we) begin
        if (cfg_index == tfc_pkg::REG_MODE) mode_reg <= tfc_pkg::mode_t'(cfg_data[1:0]);
        else sea_reg <= cfg_data;
      end
      outstanding <= color_fifo.size();
      errors      <= errors + bad;
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

  // watchdog: cycles without any transfer before the run is declared hung
  localparam int STALL_LIMIT  = 2000;
  // pipeline depth is SAMPLE_BITS + 4, with extra drain time at the end
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 130;

  // band tops and the temperature knee, used to aim samples at the edges
  localparam int BREAKS [5] = '{26214, 38011, 47186, 57016, 32768};

  // directed heights at the reset sea level: ends of range, sea edge,
  // every band top and the sample just past the beach and mountain tops
  localparam logic [15:0] HEIGHT_PROBES [10] = '{
    16'd0, 16'd22937, 16'd22938, 16'd26214, 16'd26215,
    16'd38011, 16'd47186, 16'd57016, 16'd57017, 16'd65535
  };

  // random phases: height mode gets the most time since it has the most paths
  localparam tfc_pkg::mode_t MODE_PLAN [PHASES] = '{
    tfc_pkg::MODE_HEIGHT, tfc_pkg::MODE_OCEAN, tfc_pkg::MODE_TEMP, tfc_pkg::MODE_RAIN,
    tfc_pkg::MODE_HEIGHT, tfc_pkg::MODE_HEIGHT, tfc_pkg::MODE_TEMP, tfc_pkg::MODE_RAIN,
    tfc_pkg::MODE_HEIGHT, tfc_pkg::MODE_OCEAN, tfc_pkg::MODE_HEIGHT, tfc_pkg::MODE_HEIGHT
  };
  // negative means pick a random sea level
  localparam int SEA_PLAN [PHASES] = '{
    22938, -1, -1, -1, 0, 65535, -1, 26214, 26214, -1, -1, -1
  };
  // sender idle percentage, cycled across phases
  localparam int GAP_PLAN [3] = '{0, 73, 23};

  logic        clk;
  logic        rst       = 1'b1;
  logic        start     = 1'b0;
  logic        busy;
  logic [15:0] sample    = '0;
  logic        is_ocean  = 1'b0;
  logic        done;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = tfc_pkg::REG_MODE;
  logic [15:0] cfg_data  = '0;

  int fail_cnt;
  int in_flight;
  int gap_pct      = 0;
  int stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  terrain_false_color_mapper u_dut (.*);

  // scoreboard sits beside the block and only watches its pins
  colormap_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .sample      (sample),
    .is_ocean    (is_ocean),
    .done        (done),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (fail_cnt),
    .outstanding (in_flight)
  );

  // one command transfer, with a random number of idle cycles ahead of it;
  // start is left high on return so back-to-back commands stream at full rate
  task automatic send_sample(input logic [15:0] value, input logic ocean);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    sample   <= value;
    is_ocean <= ocean;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // drain the pipe, then write both registers on back-to-back cycles
  task automatic set_config(input tfc_pkg::mode_t m, input logic [15:0] level);
    start <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= tfc_pkg::REG_MODE;
    cfg_data  <= 16'(m);
    @(posedge clk);
    cfg_index <= tfc_pkg::REG_SEA;
    cfg_data  <= level;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // half uniform samples, the rest aimed at band tops, the sea edge,
  // the temperature knee and both ends of the range
  function automatic logic [15:0] pick_sample(input logic [15:0] level);
    int kind;
    int v;
    kind = $urandom_range(9);
    case (kind)
      5:       v = BREAKS[$urandom_range(4)] + int'($urandom_range(4)) - 2;
      6:       v = int'(level) + int'($urandom_range(4)) - 2;
      7:       v = $urandom_range(1) ? 0 : 65535;
      8:       v = $urandom_range(1023);
      9:       v = 65535 - int'($urandom_range(1023));
      default: v = $urandom_range(65535);
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // hang detector: any command, result or config transfer clears it
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("terrain_false_color_mapper verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [15:0] level;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, streamed with no gaps
    // reset settings: height mode, sea at 0.35
    gap_pct = 0;
    foreach (HEIGHT_PROBES[i]) send_sample(HEIGHT_PROBES[i], i[0]);

    // sea level right on the beach top: beach band has zero width there
    set_config(tfc_pkg::MODE_HEIGHT, 16'd26214);
    send_sample(16'd26214, 1'b0);
    send_sample(16'd26213, 1'b1);

    // sea level at zero: nothing is ever under water
    set_config(tfc_pkg::MODE_HEIGHT, 16'd0);
    send_sample(16'd0, 1'b1);

    // ocean flag both ways, sample is don't-care here
    set_config(tfc_pkg::MODE_OCEAN, 16'd22938);
    send_sample(16'hffff, 1'b0);
    send_sample(16'h0000, 1'b1);

    // temperature: both ends and both sides of the half-scale knee
    set_config(tfc_pkg::MODE_TEMP, 16'd65535);
    send_sample(16'd0, 1'b0);
    send_sample(16'd32767, 1'b1);
    send_sample(16'd32768, 1'b0);
    send_sample(16'd65535, 1'b1);

    // rainfall: both ends
    set_config(tfc_pkg::MODE_RAIN, 16'd0);
    send_sample(16'd0, 1'b1);
    send_sample(16'd65535, 1'b0);

    // random part, one setting per phase, sender gaps vary by phase
    for (int ph = 0; ph < PHASES; ph++) begin
      level = (SEA_PLAN[ph] < 0) ? 16'($urandom_range(65535)) : 16'(SEA_PLAN[ph]);
      set_config(MODE_PLAN[ph], level);
      gap_pct = GAP_PLAN[ph % 3];
      repeat (PHASE_ITEMS) send_sample(pick_sample(level), 1'($urandom_range(1)));
    end

    // wait out every expected result, then a little extra for strays
    start <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("terrain_false_color_mapper verification clean");
    end else begin
      $display("terrain_false_color_mapper verification failed");
    end
    $finish;
  end

endmodule
